>>> rtl/rnsc_pkg.sv
// Package for the radix number syntax checker.
// Holds the character codes, error codes, limits and the shared struct types.
// No dependencies.
package rnsc_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned BaseW  = 9;
  localparam int unsigned ValueW = 10;
  localparam int unsigned CodeW  = 5;
  // product of a running value and ten, plus one digit
  localparam int unsigned ProdW  = ValueW + 4;

  localparam logic [BaseW-1:0]  MaxBase   = BaseW'(500);
  localparam logic [BaseW-1:0]  MinBase   = BaseW'(2);
  localparam logic [BaseW-1:0]  BaseReset = BaseW'(10);
  localparam logic [ValueW-1:0] ValueMax  = {ValueW{1'b1}};

  // configuration register indexes
  localparam logic RegBaseP = 1'b0;
  localparam logic RegBaseQ = 1'b1;

  // characters
  localparam logic [ChW-1:0] ChSpace  = 8'h20;
  localparam logic [ChW-1:0] ChLSq    = 8'h5B;
  localparam logic [ChW-1:0] ChRSq    = 8'h5D;
  localparam logic [ChW-1:0] ChLPar   = 8'h28;
  localparam logic [ChW-1:0] ChRPar   = 8'h29;
  localparam logic [ChW-1:0] ChDot    = 8'h2E;
  localparam logic [ChW-1:0] ChZero   = 8'h30;
  localparam logic [ChW-1:0] ChNine   = 8'h39;

  // error codes
  localparam logic [CodeW-1:0] ErrNone         = 5'd0;
  localparam logic [CodeW-1:0] ErrEmpty        = 5'd1;
  localparam logic [CodeW-1:0] ErrBaseP        = 5'd2;
  localparam logic [CodeW-1:0] ErrBaseQ        = 5'd3;
  localparam logic [CodeW-1:0] ErrAfterPeriod  = 5'd4;
  localparam logic [CodeW-1:0] ErrSpace        = 5'd5;
  localparam logic [CodeW-1:0] ErrNestedSq     = 5'd6;
  localparam logic [CodeW-1:0] ErrEmptyDigit   = 5'd7;
  localparam logic [CodeW-1:0] ErrStrayRSq     = 5'd8;
  localparam logic [CodeW-1:0] ErrDigitRange   = 5'd9;
  localparam logic [CodeW-1:0] ErrDotInside    = 5'd10;
  localparam logic [CodeW-1:0] ErrDotNoWhole   = 5'd11;
  localparam logic [CodeW-1:0] ErrSecondDot    = 5'd12;
  localparam logic [CodeW-1:0] ErrLParInSq     = 5'd13;
  localparam logic [CodeW-1:0] ErrLParNoDot    = 5'd14;
  localparam logic [CodeW-1:0] ErrLParInPer    = 5'd15;
  localparam logic [CodeW-1:0] ErrEmptyPeriod  = 5'd16;
  localparam logic [CodeW-1:0] ErrStrayRPar    = 5'd17;
  localparam logic [CodeW-1:0] ErrSymbol       = 5'd18;
  localparam logic [CodeW-1:0] ErrOpenBracket  = 5'd19;
  localparam logic [CodeW-1:0] ErrDotAtEnd     = 5'd20;
  localparam logic [CodeW-1:0] ErrNoWhole      = 5'd21;

  // one request as it sits in the input register
  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           char_present;
    logic           last;
  } item_t;

  // one result
  typedef struct packed {
    logic             accepted;
    logic [CodeW-1:0] error_code;
  } result_t;

  // parser state
  typedef struct packed {
    logic              square_open;
    logic              period_open;
    logic              period_closed;
    logic              dot_seen;
    logic              whole_present;
    logic              fraction_present;
    logic              period_present;
    logic              digits_pending;
    logic [ValueW-1:0] digit_value;
    logic              halted;
    logic [CodeW-1:0]  first_error;
  } parse_state_t;

endpackage

>>> rtl/rnsc_parse.sv
// Parser state and per-character check for the radix number syntax checker.
// Updates the state by one character per step and forms the result on the last one.
// Depends on rnsc_pkg.
module rnsc_parse (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  rnsc_pkg::item_t                  item_i,
  input  logic [rnsc_pkg::BaseW-1:0]       base_p_i,
  input  logic [rnsc_pkg::BaseW-1:0]       base_q_i,
  output rnsc_pkg::result_t                result_o
);
  import rnsc_pkg::*;

  parse_state_t     st_q, st_d, st_chk;
  logic [CodeW-1:0] chk_err;
  logic [ProdW-1:0] prod;
  logic             started;
  logic [CodeW-1:0] code;

  // running digit value times ten plus the new digit; saturated where it is stored
  assign prod = ({4'b0, st_q.digit_value} << 3) + ({4'b0, st_q.digit_value} << 1)
              + ProdW'(item_i.ch - ChZero);

  // check one character against the current state
  always_comb begin
    st_chk  = st_q;
    chk_err = ErrNone;
    if (st_q.period_closed) begin
      chk_err = ErrAfterPeriod;
    end else begin
      case (item_i.ch) inside
        ChSpace: chk_err = ErrSpace;
        ChLSq: begin
          if (st_q.square_open) chk_err = ErrNestedSq;
          else st_chk.square_open = 1'b1;
        end
        ChRSq: begin
          if (!st_q.digits_pending) chk_err = ErrEmptyDigit;
          else if (!st_q.square_open) chk_err = ErrStrayRSq;
          else if (st_q.digit_value >= {1'b0, base_p_i}) chk_err = ErrDigitRange;
          else begin
            st_chk.square_open    = 1'b0;
            st_chk.digits_pending = 1'b0;
            st_chk.digit_value    = '0;
            if (st_q.dot_seen && !st_q.period_open) st_chk.fraction_present = 1'b1;
            if (!st_q.dot_seen) st_chk.whole_present = 1'b1;
            if (st_q.period_open) st_chk.period_present = 1'b1;
          end
        end
        ChDot: begin
          if (st_q.square_open || st_q.period_open) chk_err = ErrDotInside;
          else if (!st_q.whole_present) chk_err = ErrDotNoWhole;
          else if (st_q.dot_seen) chk_err = ErrSecondDot;
          else st_chk.dot_seen = 1'b1;
        end
        ChLPar: begin
          if (st_q.square_open) chk_err = ErrLParInSq;
          else if (!st_q.dot_seen) chk_err = ErrLParNoDot;
          else if (st_q.period_open) chk_err = ErrLParInPer;
          else st_chk.period_open = 1'b1;
        end
        ChRPar: begin
          if (!st_q.period_present) chk_err = ErrEmptyPeriod;
          else if (!st_q.period_open) chk_err = ErrStrayRPar;
          else begin
            st_chk.period_open   = 1'b0;
            st_chk.period_closed = 1'b1;
          end
        end
        [ChZero:ChNine]: begin
          st_chk.digits_pending = 1'b1;
          st_chk.digit_value    = (prod > ProdW'(ValueMax)) ? ValueMax
                                                            : prod[ValueW-1:0];
        end
        default: chk_err = ErrSymbol;
      endcase
    end
    // a fault keeps the state and stops checking until the end of the string
    if (chk_err != ErrNone) begin
      st_chk             = st_q;
      st_chk.halted      = 1'b1;
      st_chk.first_error = chk_err;
    end
  end

  // end-of-string result, in order of precedence
  assign started = (st_q != '0);

  always_comb begin
    if (!item_i.char_present && !started) begin
      code = ErrEmpty;
    end else if (base_p_i < MinBase || base_p_i > MaxBase) begin
      code = ErrBaseP;
    end else if (base_q_i < MinBase || base_q_i > MaxBase) begin
      code = ErrBaseQ;
    end else if (st_d.first_error != ErrNone) begin
      code = st_d.first_error;
    end else if (st_d.square_open || st_d.period_open) begin
      code = ErrOpenBracket;
    end else if (st_d.dot_seen && !st_d.fraction_present && !st_d.period_present) begin
      code = ErrDotAtEnd;
    end else if (!st_d.whole_present) begin
      code = ErrNoWhole;
    end else begin
      code = ErrNone;
    end
  end

  // state after this character, before any clear
  assign st_d = (item_i.char_present && !st_q.halted) ? st_chk : st_q;

  assign result_o.accepted   = (code == ErrNone);
  assign result_o.error_code = code;

  // state register; the last character clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= item_i.last ? '0 : st_d;
    end
  end

endmodule

>>> rtl/radix_number_syntax_checker_top.sv
// Top level of the radix number syntax checker.
// Input register, configuration registers, parser and output register.
// Depends on rnsc_pkg and rnsc_parse.
// A request is registered, then checked; its result goes to the output register.
// Throughput: one character per cycle, unless a last character waits on a blocked result output.
// Reset: asynchronous, active low; clears the parser state and valid flags,
// and sets base_p and base_q to 10.
module radix_number_syntax_checker_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [rnsc_pkg::BaseW-1:0]  cfg_wdata_i,
  // character stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] ch
  input  logic                        s_axis_tuser,   // [0] char_present
  input  logic                        s_axis_tlast,   // last
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata    // [0] accepted, [5:1] error_code, [7:6] zero
);
  import rnsc_pkg::*;

  logic [BaseW-1:0] base_p_q, base_q_q;
  logic             in_valid_q;
  item_t            in_q;
  logic             step;
  result_t          res;
  logic             out_valid_q;
  result_t          out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_p_q <= BaseReset;
      base_q_q <= BaseReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegBaseP) base_p_q <= cfg_wdata_i;
      if (cfg_idx_i == RegBaseQ) base_q_q <= cfg_wdata_i;
    end
  end

  // the held request moves on unless it carries a result and the output is blocked
  assign step          = in_valid_q && (!in_q.last || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.ch           <= s_axis_tdata;
      in_q.char_present <= s_axis_tuser;
      in_q.last         <= s_axis_tlast;
    end
  end

  rnsc_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .base_p_i (base_p_q),
    .base_q_i (base_q_q),
    .result_o (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_q.last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_q.last) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.error_code, out_q.accepted};

endmodule
